>>> rtl/sctt_pkg.sv
// -----------------------------------------------------------------------------
// Slowest-client clock table package
// Widths, command and status codes, and the types shared by the cells and the
// top level.
// -----------------------------------------------------------------------------
package sctt_pkg;

   localparam int OPCODE_W = 2;
   localparam int SLOT_W   = 6;
   localparam int CLOCK_W  = 31;
   localparam int STATUS_W = 3;

   localparam logic [CLOCK_W-1:0] CLOCK_MAX = {CLOCK_W{1'b1}};

   // Command codes.
   localparam logic [OPCODE_W-1:0] OP_ADD          = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TICK         = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ_CLIENT  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_READ_SLOWEST = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd4;

   // Command as captured from the request channel and broadcast to the cells.
   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [SLOT_W-1:0]   client_slot;
      logic [CLOCK_W-1:0]  start_time;
   } cmd_type;

   // Data rippled from cell to cell.
   typedef struct packed {
      logic               present;  // the selected slot holds a client
      logic [CLOCK_W-1:0] clock;    // clock of the selected slot
      logic               other;    // an unselected client sits at the minimum
   } chain_type;

endpackage

>>> rtl/sctt_req_if.sv
// -----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel that carries one command beat.
// -----------------------------------------------------------------------------
interface sctt_req_if;
   import sctt_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [SLOT_W-1:0]   client_slot;
   logic [CLOCK_W-1:0]  start_time;

   modport source (output valid, output opcode, output client_slot, output start_time,
                   input ready);
   modport sink   (input valid, input opcode, input client_slot, input start_time,
                   output ready);
endinterface

// -----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel that carries one result beat.
// -----------------------------------------------------------------------------
interface sctt_rsp_if;
   import sctt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [CLOCK_W-1:0]  clock_value;
   logic                advanced;

   modport source (output valid, output status, output clock_value, output advanced,
                   input ready);
   modport sink   (input valid, input status, input clock_value, input advanced,
                   output ready);
endinterface

>>> rtl/sctt_cell.sv
// -----------------------------------------------------------------------------
// Clock table cell
// Holds one client slot and merges its view into the data rippled along the row.
// -----------------------------------------------------------------------------
module sctt_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  sctt_pkg::cmd_type          cmd,
   input  logic                       sel,
   input  logic                       commit,
   input  logic [sctt_pkg::CLOCK_W-1:0] slowest,
   input  sctt_pkg::chain_type        chain_in,
   output sctt_pkg::chain_type        chain_out
);
   import sctt_pkg::*;

   logic               present_ff;
   logic               present_in;
   logic [CLOCK_W-1:0] clock_ff;
   logic [CLOCK_W-1:0] clock_in;
   logic               hit;

   always_comb begin
      hit               = present_ff && (clock_ff == slowest);
      chain_out.present = chain_in.present | (sel & present_ff);
      chain_out.clock   = chain_in.clock | ((sel && present_ff) ? clock_ff : '0);
      chain_out.other   = chain_in.other | (hit & ~sel);
   end

   always_comb begin
      present_in = present_ff;
      clock_in   = clock_ff;
      if (commit && sel) begin
         unique case (cmd.opcode)
            OP_ADD: begin
               if (!present_ff) begin
                  clock_in   = cmd.start_time;
                  present_in = 1'b1;
               end
            end
            OP_TICK: begin
               if (present_ff && (clock_ff != CLOCK_MAX)) begin
                  clock_in = clock_ff + 1'b1;
               end
            end
            OP_READ_CLIENT: begin
            end
            OP_READ_SLOWEST: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b0;
      end else begin
         present_ff <= present_in;
      end
   end

   always_ff @(posedge clock) begin
      clock_ff <= clock_in;
   end

endmodule

>>> rtl/slowest_client_clock_table.sv
// -----------------------------------------------------------------------------
// Slowest-client clock table
// Per-client clocks in a row of cells, with the minimum over present clients.
// -----------------------------------------------------------------------------
//
//   Channel  Direction  Beat contents
//   -------  ---------  ---------------------------------------------
//   req_if   in         opcode, client_slot, start_time
//   rsp_if   out        status, clock_value, advanced
//
// For each command beat the accept edge captures the command,
// and in the following cycle every cell compares its clock with the minimum
// while the row ripples the selected clock and the "another holder" flag to
// the end, where the result is formed, the cells update and the result
// register loads. The single result register sets the pace: if the previous
// result has not been taken, the execute cycle waits. Reset clears all
// present bits and the minimum at once; there is no clearing pass. Client
// clocks are never reset, since a slot is only read once an add has written it.
//
module slowest_client_clock_table #(
   parameter int CLIENT_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   sctt_req_if.sink    req_if,
   sctt_rsp_if.source  rsp_if
);
   import sctt_pkg::*;

   // Sequencer states.
   localparam logic FSM_IDLE = 1'b0;
   localparam logic FSM_EXEC = 1'b1;

   logic               state_ff;
   logic               state_in;
   cmd_type            cmd_ff;
   cmd_type            cmd_in;

   // Minimum clock over the present clients, and whether any client exists.
   logic [CLOCK_W-1:0] slowest_ff;
   logic [CLOCK_W-1:0] slowest_in;
   logic               known_ff;
   logic               known_in;

   // Result register.
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [CLOCK_W-1:0]  value_ff;
   logic [CLOCK_W-1:0]  value_in;
   logic                adv_ff;
   logic                adv_in;

   logic                    commit;
   logic                    slot_in_range;
   logic [CLIENT_SLOTS-1:0] sel;
   chain_type               chain [CLIENT_SLOTS+1];

   // The execute cycle finishes only when the result register is free.
   assign commit        = (state_ff == FSM_EXEC) && (!rsp_valid_ff || rsp_if.ready);
   assign slot_in_range = 32'(cmd_ff.client_slot) < 32'(CLIENT_SLOTS);
   assign chain[0]      = '0;

   assign req_if.ready = (state_ff == FSM_IDLE);

   // The row of cells. A slot number beyond the row selects no cell, so it
   // reads back as an absent client.
   for (genvar i = 0; i < CLIENT_SLOTS; i++) begin : g_cell
      assign sel[i] = (32'(cmd_ff.client_slot) == 32'(i));

      sctt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd_ff),
         .sel       (sel[i]),
         .commit    (commit),
         .slowest   (slowest_ff),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1])
      );
   end

   // Result and minimum update, decided from the end of the row.
   always_comb begin
      status_in  = STATUS_OK;
      value_in   = '0;
      adv_in     = 1'b0;
      slowest_in = slowest_ff;
      known_in   = known_ff;
      unique case (cmd_ff.opcode)
         OP_ADD: begin
            if (!slot_in_range) begin
               status_in = STATUS_ABSENT;
            end else if (chain[CLIENT_SLOTS].present) begin
               status_in = STATUS_PRESENT;
            end else if (!known_ff || (cmd_ff.start_time < slowest_ff)) begin
               slowest_in = cmd_ff.start_time;
               known_in   = 1'b1;
            end
         end
         OP_TICK: begin
            // A client that alone sits at the minimum drags it up by one.
            if (!chain[CLIENT_SLOTS].present) begin
               status_in = STATUS_ABSENT;
            end else if (chain[CLIENT_SLOTS].clock == CLOCK_MAX) begin
               status_in = STATUS_OVERFLOW;
            end else if ((chain[CLIENT_SLOTS].clock == slowest_ff) &&
                         !chain[CLIENT_SLOTS].other) begin
               slowest_in = slowest_ff + 1'b1;
               value_in   = slowest_ff + 1'b1;
               adv_in     = 1'b1;
            end
         end
         OP_READ_CLIENT: begin
            if (!chain[CLIENT_SLOTS].present) begin
               status_in = STATUS_ABSENT;
            end else begin
               value_in = chain[CLIENT_SLOTS].clock;
            end
         end
         OP_READ_SLOWEST: begin
            if (!known_ff) begin
               status_in = STATUS_EMPTY;
            end else begin
               value_in = slowest_ff;
            end
         end
      endcase
   end

   // Sequencer and result handshake.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_if.valid) begin
               cmd_in.opcode      = req_if.opcode;
               cmd_in.client_slot = req_if.client_slot;
               cmd_in.start_time  = req_if.start_time;
               state_in           = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (commit) begin
               rsp_valid_in = 1'b1;
               state_in     = FSM_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
         slowest_ff   <= '0;
         known_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            slowest_ff <= slowest_in;
            known_ff   <= known_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (commit) begin
         status_ff <= status_in;
         value_ff  <= value_in;
         adv_ff    <= adv_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = status_ff;
   assign rsp_if.clock_value = value_ff;
   assign rsp_if.advanced    = adv_ff;

`ifndef SYNTH
   // An advancing tick always reports success.
   a_adv_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && adv_ff) |-> (status_ff == STATUS_OK))
      else $error("advanced result without ok status");

   // The reported new minimum is the one the table now holds.
   a_adv_value: assert property (@(posedge clock) disable iff (reset)
      (commit && adv_in) |=> (value_ff == slowest_ff))
      else $error("advanced value differs from stored minimum");

   // A finished execute cycle always leaves a result beat waiting.
   a_exec_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> (rsp_valid_ff && (state_ff == FSM_IDLE)))
      else $error("execute cycle produced no result");

   // The minimum only moves while a command commits.
   a_min_stable: assert property (@(posedge clock) disable iff (reset)
      !commit |=> ($stable(slowest_ff) && $stable(known_ff)))
      else $error("minimum changed outside a command");
`endif

endmodule

>>> bench/clock_table_checker.sv
// -----------------------------------------------------------------------------
// Clock table checker
// Watches the command and result channels, keeps its own copy of the client
// table, works out the result of every accepted command and compares each
// returned result with the oldest one still owed.
// -----------------------------------------------------------------------------
module clock_table_checker #(
   parameter int CLIENT_SLOTS = 64
) (
   input  logic clock,
   input  logic reset,
   sctt_req_if  req_mon,
   sctt_rsp_if  rsp_mon,
   output int   fail_count,
   output int   results_owed
);
   import sctt_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CLOCK_W-1:0]  clock_value;
      logic                advanced;
   } clock_result_type;

   logic [CLOCK_W-1:0]      client_clock [CLIENT_SLOTS];
   logic [CLIENT_SLOTS-1:0] client_present;
   logic [CLOCK_W-1:0]      slowest_clock;
   logic                    slowest_known;
   clock_result_type        owed_results [$];
   int                      result_index;

   task automatic report_error(input string msg);
      $display("%0t clock table check: %s", $time, msg);
      fail_count++;
   endtask

   // Applies one command to the table copy and returns the result it earns.
   function automatic clock_result_type apply_command(input logic [OPCODE_W-1:0] op,
                                                      input logic [SLOT_W-1:0]   slot,
                                                      input logic [CLOCK_W-1:0]  start);
      clock_result_type res;
      logic             here;
      int               holders;
      res   = '{status: STATUS_OK, clock_value: '0, advanced: 1'b0};
      here  = (int'(slot) < CLIENT_SLOTS) && client_present[slot];
      case (op)
         OP_ADD: begin
            if (int'(slot) >= CLIENT_SLOTS) begin
               res.status = STATUS_ABSENT;
            end else if (here) begin
               res.status = STATUS_PRESENT;
            end else begin
               client_clock[slot]   = start;
               client_present[slot] = 1'b1;
               if (!slowest_known || start < slowest_clock) begin
                  slowest_clock = start;
                  slowest_known = 1'b1;
               end
            end
         end
         OP_TICK: begin
            if (!here) begin
               res.status = STATUS_ABSENT;
            end else if (client_clock[slot] == CLOCK_MAX) begin
               res.status = STATUS_OVERFLOW;
            end else begin
               holders = 0;
               for (int i = 0; i < CLIENT_SLOTS; i++)
                  if (client_present[i] && client_clock[i] == slowest_clock) holders++;
               // Only a lone holder of the minimum drags the minimum up with it.
               if (client_clock[slot] == slowest_clock && holders == 1) begin
                  slowest_clock   = slowest_clock + 1'b1;
                  res.clock_value = slowest_clock;
                  res.advanced    = 1'b1;
               end
               client_clock[slot] = client_clock[slot] + 1'b1;
            end
         end
         OP_READ_CLIENT: begin
            if (!here) res.status = STATUS_ABSENT;
            else res.clock_value = client_clock[slot];
         end
         default: begin
            if (!slowest_known) res.status = STATUS_EMPTY;
            else res.clock_value = slowest_clock;
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      clock_result_type want;
      if (reset) begin
         for (int i = 0; i < CLIENT_SLOTS; i++) client_clock[i] = '0;
         client_present = '0;
         slowest_clock  = '0;
         slowest_known  = 1'b0;
         fail_count     = 0;
         result_index   = 0;
         owed_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_results.size() == 0) begin
               report_error("result beat arrived with nothing owed");
            end else begin
               want = owed_results.pop_front();
               if (rsp_mon.status !== want.status)
                  report_error($sformatf("result %0d status: expected %0d, got %0d",
                                         result_index, want.status, rsp_mon.status));
               if (rsp_mon.clock_value !== want.clock_value)
                  report_error($sformatf("result %0d clock_value: expected %0d, got %0d",
                                         result_index, want.clock_value,
                                         rsp_mon.clock_value));
               if (rsp_mon.advanced !== want.advanced)
                  report_error($sformatf("result %0d advanced: expected %0b, got %0b",
                                         result_index, want.advanced, rsp_mon.advanced));
            end
            result_index++;
         end
         if (req_mon.valid && req_mon.ready)
            owed_results.push_back(apply_command(req_mon.opcode, req_mon.client_slot,
                                                 req_mon.start_time));
      end
      results_owed = owed_results.size();
   end

endmodule

>>> bench/slowest_client_clock_table_test.sv
// -----------------------------------------------------------------------------
// Slowest-client clock table test
// Drives directed and random command beats into the table with random gaps on
// both channels, while a checker beside the block predicts and compares every
// result beat. Prints the verdict at the end of the run.
// -----------------------------------------------------------------------------
module slowest_client_clock_table_test;
   import sctt_pkg::*;

   localparam int CLIENT_SLOTS = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // When set, neither the command sender nor the result taker leaves gaps.
   logic steady;

   // Slots that have seen an add; used only to aim ticks and reads at clients.
   logic [CLIENT_SLOTS-1:0] added_slots;

   int fail_count;
   int results_owed;

   sctt_req_if req_ch ();
   sctt_rsp_if rsp_ch ();

   slowest_client_clock_table #(
      .CLIENT_SLOTS (CLIENT_SLOTS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   clock_table_checker #(
      .CLIENT_SLOTS (CLIENT_SLOTS)
   ) checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The result side drops ready with a chance of 27 in a hundred, except while
   // the steady stretch runs. It changes only at the falling edge.
   always @(negedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 27);
   end

   // Sends one command beat. The task starts and ends at a falling edge. Gaps
   // before the beat are drawn one at a time, so the sender can leave a run
   // of gaps in a row. The beat is held until the block takes it.
   task automatic send_cmd(input logic [OPCODE_W-1:0] op,
                           input logic [SLOT_W-1:0]   slot,
                           input logic [CLOCK_W-1:0]  start);
      while (!steady && $urandom_range(0, 99) < 27) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= op;
      req_ch.client_slot <= slot;
      req_ch.start_time  <= start;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      if (op == OP_ADD) added_slots[slot] = 1'b1;
   endtask

   // Lowers valid and waits until every result owed has come back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
   endtask

   // One random command. Slots are drawn below span, so a small span keeps
   // only a handful of clients in play and lets the minimum move often. Most
   // ticks and reads are aimed at clients that exist; the rest go to any
   // slot. Add times are mostly small so clients collide on the minimum,
   // with a few near the top of the clock range to reach the overflow case
   // and a few across the whole range so every bit toggles.
   task automatic send_random(input int span);
      logic [OPCODE_W-1:0] op;
      logic [SLOT_W-1:0]   slot;
      logic [CLOCK_W-1:0]  start;
      int                  pick;
      pick = $urandom_range(0, 99);
      if (pick < 15)      op = OP_ADD;
      else if (pick < 60) op = OP_TICK;
      else if (pick < 82) op = OP_READ_CLIENT;
      else                op = OP_READ_SLOWEST;

      slot = SLOT_W'($urandom_range(0, span - 1));
      if (op != OP_ADD && $urandom_range(0, 99) < 85) begin
         repeat (16)
            if (!added_slots[slot]) slot = SLOT_W'($urandom_range(0, span - 1));
      end

      pick = $urandom_range(0, 99);
      if (op != OP_ADD)  start = CLOCK_W'($urandom());
      else if (pick < 80) start = CLOCK_W'($urandom_range(0, 12));
      else if (pick < 90) start = CLOCK_MAX - CLOCK_W'($urandom_range(0, 3));
      else               start = CLOCK_W'($urandom());
      send_cmd(op, slot, start);
   endtask

   initial begin
      steady             = 1'b0;
      added_slots        = '0;
      req_ch.valid       = 1'b0;
      req_ch.opcode      = OP_ADD;
      req_ch.client_slot = '0;
      req_ch.start_time  = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. The empty table answers the slowest read with the
      // empty status, and ticks or reads of a missing client come back absent.
      send_cmd(OP_READ_SLOWEST, 6'd0, '0);
      send_cmd(OP_READ_CLIENT, 6'd5, CLOCK_MAX);
      send_cmd(OP_TICK, 6'd5, '0);
      // Clients at both ends of the clock range, then a duplicate add.
      send_cmd(OP_ADD, 6'd0, '0);
      send_cmd(OP_ADD, 6'd63, CLOCK_MAX);
      send_cmd(OP_ADD, 6'd0, 31'd7);
      // A client already at the largest clock refuses to tick.
      send_cmd(OP_TICK, 6'd63, '0);
      send_cmd(OP_READ_CLIENT, 6'd63, '0);
      send_cmd(OP_READ_SLOWEST, 6'd0, '0);
      // Slot 0 holds the minimum alone, so its tick advances the minimum.
      send_cmd(OP_TICK, 6'd0, '0);
      // A second client joins at the minimum; a tick of a shared holder does
      // not advance, but the one left behind then advances it.
      send_cmd(OP_ADD, 6'd42, 31'd1);
      send_cmd(OP_TICK, 6'd0, '0);
      send_cmd(OP_TICK, 6'd42, '0);
      send_cmd(OP_TICK, 6'd0, '0);
      // Alternating bit patterns in slots and times, well above the minimum.
      send_cmd(OP_ADD, 6'd21, 31'h2AAA_AAAA);
      send_cmd(OP_ADD, 6'd10, 31'h5555_5555);
      send_cmd(OP_READ_CLIENT, 6'd21, '0);
      send_cmd(OP_TICK, 6'd21, '0);
      // A late add below the minimum pulls it down, then advances it twice.
      send_cmd(OP_ADD, 6'd30, '0);
      send_cmd(OP_READ_SLOWEST, 6'd0, '0);
      send_cmd(OP_TICK, 6'd30, '0);
      send_cmd(OP_TICK, 6'd30, '0);
      send_cmd(OP_READ_CLIENT, 6'd30, '0);
      send_cmd(OP_READ_SLOWEST, 6'd0, '0);

      // The sender holds off here until the table has answered everything.
      drain_results();

      // First random part: a few clients only, so the minimum keeps moving.
      // A long stretch in the middle runs with no gaps on either side.
      for (int n = 0; n < 900; n++) begin
         steady = (n >= 300 && n < 450);
         send_random(8);
      end
      steady = 1'b0;
      drain_results();

      // Second random part: commands spread across the whole table.
      for (int n = 0; n < 430; n++) send_random(CLIENT_SLOTS);

      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && results_owed == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Guard against a hung handshake; far beyond the slowest correct run.
   initial begin
      #2400000;
      $display("status: fail");
      $finish;
   end

endmodule
